// ===== hw/rtl/etp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Embedded template tokenizer package
// Shared types and constants for the scanner front end, queue and emitter.
// ----------------------------------------------------------------------------
package etp_pkg;

  localparam int HOLD_CAP = 32;
  localparam int CMD_BYTES = 4;

  localparam logic [2:0] KIND_TEXT    = 3'd0;
  localparam logic [2:0] KIND_CODE    = 3'd1;
  localparam logic [2:0] KIND_PUT     = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_PLINE   = 3'd4;

  localparam logic [1:0] REG_TRIM_SELECT   = 2'd0;
  localparam logic [1:0] REG_PERCENT_LINES = 2'd1;
  localparam logic [1:0] REG_DASH_TRIM     = 2'd2;

  localparam logic [1:0] TRIM_ALWAYS    = 2'd1;
  localparam logic [1:0] TRIM_LINE_HEAD = 2'd2;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;

  typedef enum logic [3:0] {
    PH_TEXT, PH_LT, PH_LTPCT, PH_PCTHEAD, PH_PLINE, PH_BODY, PH_BPCT,
    PH_BPCTPCT, PH_BDASH, PH_BDASHPCT, PH_TRIM, PH_TRIMCR
  } phase_t;

  // One scanned input byte: held whitespace released, bytes of the segment
  // open at the start, its close marker, then bytes and marker of the next.
  typedef struct packed {
    logic [5:0]                 rel_n;
    logic [HOLD_CAP-1:0]        rel_mask;
    logic [2:0]                 kind_a;
    logic [CMD_BYTES-1:0][7:0]  a_bytes;
    logic [2:0]                 a_n;
    logic                       mark_a;
    logic [2:0]                 kind_b;
    logic [CMD_BYTES-1:0][7:0]  b_bytes;
    logic [2:0]                 b_n;
    logic                       mark_b;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] segment_kind;
    logic       segment_end;
    logic       run_last;
  } res_t;

  typedef struct packed {
    phase_t              phase;
    logic                alh;
    logic                tbl;
    logic [2:0]          okind;
    logic                has;
    logic [5:0]          cnt;
    logic                lwo;
    logic [HOLD_CAP-1:0] held;
    logic                closed;
    cmd_t                c;
  } ctx_t;

endpackage
`default_nettype wire

// ===== hw/rtl/etp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner front end
// Classifies each template byte and emits one command per byte that yields
// results.
// ----------------------------------------------------------------------------
module etp_front #(
  parameter int WS_DEPTH = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  input  wire logic [1:0]    trim_select,
  input  wire logic          percent_lines,
  input  wire logic          dash_trim,
  output logic               push,
  output etp_pkg::cmd_t      push_cmd,
  input  wire logic          q_full
);
  import etp_pkg::*;

  localparam int HOLD_LIMIT = (WS_DEPTH < HOLD_CAP) ? WS_DEPTH : HOLD_CAP;
  localparam logic [5:0] LIM = 6'(HOLD_LIMIT);

  phase_t              phase;
  logic                alh, tbl, has, lwo;
  logic [2:0]          okind;
  logic [5:0]          cnt;
  logic [HOLD_CAP-1:0] held;
  ctx_t                x;
  logic [6:0]          total;

  function automatic ctx_t f_emit(ctx_t v, logic [7:0] b);
    if (!v.closed) begin
      v.c.a_bytes[v.c.a_n[1:0]] = b;
      v.c.a_n = v.c.a_n + 3'd1;
    end else begin
      v.c.b_bytes[v.c.b_n[1:0]] = b;
      v.c.b_n = v.c.b_n + 3'd1;
      v.c.kind_b = v.okind;
    end
    v.has = 1'b1;
    return v;
  endfunction

  function automatic ctx_t f_close(ctx_t v);
    if (v.has) begin
      if (!v.closed) begin
        v.c.mark_a = 1'b1;
      end else begin
        v.c.mark_b = 1'b1;
        v.c.kind_b = v.okind;
      end
    end
    v.has = 1'b0;
    v.closed = 1'b1;
    return v;
  endfunction

  function automatic ctx_t f_open(ctx_t v, logic [2:0] k);
    v.okind = k;
    v.has = 1'b0;
    v.lwo = 1'b1;
    return v;
  endfunction

  function automatic ctx_t f_release(ctx_t v);
    if (v.cnt != 6'd0) begin
      v.c.rel_n = v.cnt;
      v.c.rel_mask = v.held;
      v.has = 1'b1;
    end
    v.cnt = 6'd0;
    return v;
  endfunction

  function automatic ctx_t f_text(ctx_t v, logic [7:0] b, logic pl, logic dt);
    v.phase = PH_TEXT;
    if (b == CH_LT) begin
      v.tbl = v.alh;
      v.alh = 1'b0;
      v.phase = PH_LT;
    end else if (b == CH_PCT && v.alh && pl) begin
      v.alh = 1'b0;
      v.phase = PH_PCTHEAD;
    end else if (b == CH_SP || b == CH_TAB) begin
      v.alh = 1'b0;
      if (v.lwo && dt && v.cnt < LIM) begin
        v.held[v.cnt[4:0]] = (b == CH_TAB);
        v.cnt = v.cnt + 6'd1;
      end else begin
        v = f_release(v);
        v.lwo = 1'b0;
        v = f_emit(v, b);
      end
    end else begin
      v = f_release(v);
      v = f_emit(v, b);
      v.alh = (b == CH_LF);
      v.lwo = (b == CH_LF);
    end
    return v;
  endfunction

  function automatic ctx_t f_body(ctx_t v, logic [7:0] b, logic dt);
    v.phase = PH_BODY;
    if (b == CH_PCT) v.phase = PH_BPCT;
    else if (b == CH_DASH && dt) v.phase = PH_BDASH;
    else v = f_emit(v, b);
    return v;
  endfunction

  function automatic ctx_t f_close_tag(ctx_t v, logic dash, logic [1:0] ts);
    v = f_close(v);
    v = f_open(v, KIND_TEXT);
    if (dash || ts == TRIM_ALWAYS || (ts == TRIM_LINE_HEAD && v.tbl)) begin
      v.phase = PH_TRIM;
    end else begin
      v.phase = PH_TEXT;
      v.alh = 1'b0;
    end
    return v;
  endfunction

  function automatic ctx_t f_bpct(ctx_t v, logic [7:0] b, logic dt, logic [1:0] ts);
    if (b == CH_GT) v = f_close_tag(v, 1'b0, ts);
    else if (b == CH_PCT) v.phase = PH_BPCTPCT;
    else begin
      v = f_emit(v, CH_PCT);
      v = f_body(v, b, dt);
    end
    return v;
  endfunction

  function automatic ctx_t f_open_tag(ctx_t v, logic [2:0] k);
    v = f_release(v);
    v = f_close(v);
    v = f_open(v, k);
    v.phase = PH_BODY;
    return v;
  endfunction

  function automatic ctx_t f_step(ctx_t v, logic [7:0] b, logic last,
                                  logic [1:0] ts, logic pl, logic dt);
    case (v.phase)
      PH_LT: begin
        if (b == CH_PCT) begin
          v.phase = PH_LTPCT;
        end else begin
          v = f_release(v);
          v = f_emit(v, CH_LT);
          v.lwo = 1'b0;
          v = f_text(v, b, pl, dt);
        end
      end
      PH_LTPCT: begin
        if (b == CH_PCT) begin
          v = f_release(v);
          v = f_emit(v, CH_LT);
          v = f_emit(v, CH_PCT);
          v.lwo = 1'b0;
          v.phase = PH_TEXT;
        end else if (b == CH_EQ) begin
          v = f_open_tag(v, KIND_PUT);
        end else if (b == CH_HASH) begin
          v = f_open_tag(v, KIND_COMMENT);
        end else if (b == CH_DASH && dt && !last) begin
          v.cnt = 6'd0;
          v = f_open_tag(v, KIND_CODE);
        end else begin
          v = f_open_tag(v, KIND_CODE);
          v = f_body(v, b, dt);
        end
      end
      PH_PCTHEAD, PH_PLINE: begin
        if (v.phase == PH_PCTHEAD) begin
          v = f_release(v);
        end
        if (v.phase == PH_PCTHEAD && b == CH_PCT) begin
          v = f_emit(v, CH_PCT);
          v.lwo = 1'b0;
          v.phase = PH_TEXT;
        end else begin
          if (v.phase == PH_PCTHEAD) begin
            v = f_close(v);
            v = f_open(v, KIND_PLINE);
            v.phase = PH_PLINE;
          end
          v = f_emit(v, b);
          if (b == CH_LF) begin
            v = f_close(v);
            v = f_open(v, KIND_TEXT);
            v.alh = 1'b1;
            v.phase = PH_TEXT;
          end
        end
      end
      PH_BODY: v = f_body(v, b, dt);
      PH_BPCT: v = f_bpct(v, b, dt, ts);
      PH_BPCTPCT: begin
        if (b == CH_GT) begin
          v = f_emit(v, CH_PCT);
          v = f_emit(v, CH_GT);
          v.phase = PH_BODY;
        end else if (b == CH_PCT) begin
          v = f_emit(v, CH_PCT);
        end else begin
          v = f_emit(v, CH_PCT);
          v = f_emit(v, CH_PCT);
          v = f_body(v, b, dt);
        end
      end
      PH_BDASH: begin
        if (b == CH_PCT) v.phase = PH_BDASHPCT;
        else begin
          v = f_emit(v, CH_DASH);
          v = f_body(v, b, dt);
        end
      end
      PH_BDASHPCT: begin
        if (b == CH_GT) v = f_close_tag(v, 1'b1, ts);
        else begin
          v = f_emit(v, CH_DASH);
          v.phase = PH_BPCT;
          v = f_bpct(v, b, dt, ts);
        end
      end
      PH_TRIM: begin
        if (b == CH_CR) begin
          v.alh = 1'b1;
          v.phase = PH_TRIMCR;
        end else if (b == CH_LF) begin
          v.alh = 1'b1;
          v.phase = PH_TEXT;
        end else begin
          v.alh = 1'b0;
          v = f_text(v, b, pl, dt);
        end
      end
      PH_TRIMCR: begin
        v.alh = 1'b1;
        if (b == CH_LF) v.phase = PH_TEXT;
        else v = f_text(v, b, pl, dt);
      end
      default: v = f_text(v, b, pl, dt);
    endcase
    return v;
  endfunction

  function automatic ctx_t f_flush(ctx_t v);
    v = f_release(v);
    case (v.phase)
      PH_LT:   v = f_emit(v, CH_LT);
      PH_BPCT: v = f_emit(v, CH_PCT);
      PH_BPCTPCT: begin
        v = f_emit(v, CH_PCT);
        v = f_emit(v, CH_PCT);
      end
      PH_BDASH: v = f_emit(v, CH_DASH);
      PH_BDASHPCT: begin
        v = f_emit(v, CH_DASH);
        v = f_emit(v, CH_PCT);
      end
      default: ;
    endcase
    v = f_close(v);
    v.phase = PH_TEXT;
    v.alh = 1'b1;
    v.tbl = 1'b0;
    v.okind = KIND_TEXT;
    v.has = 1'b0;
    v.cnt = 6'd0;
    v.lwo = 1'b1;
    return v;
  endfunction

  always_comb begin
    x = '0;
    x.phase = phase;
    x.alh = alh;
    x.tbl = tbl;
    x.okind = okind;
    x.has = has;
    x.cnt = cnt;
    x.lwo = lwo;
    x.held = held;
    x.c.kind_a = okind;
    x = f_step(x, in_byte, in_last, trim_select, percent_lines, dash_trim);
    if (in_last) begin
      x = f_flush(x);
    end
    total = 7'(x.c.rel_n) + 7'(x.c.a_n) + 7'(x.c.mark_a) + 7'(x.c.b_n) + 7'(x.c.mark_b);
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready && (total != 7'd0);
  assign push_cmd = x.c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TEXT;
      alh   <= 1'b1;
      tbl   <= 1'b0;
      okind <= KIND_TEXT;
      has   <= 1'b0;
      cnt   <= 6'd0;
      lwo   <= 1'b1;
    end else if (in_valid && in_ready) begin
      phase <= x.phase;
      alh   <= x.alh;
      tbl   <= x.tbl;
      okind <= x.okind;
      has   <= x.has;
      cnt   <= x.cnt;
      lwo   <= x.lwo;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= x.held;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/etp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the scanner and the result emitter.
// ----------------------------------------------------------------------------
module etp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  etp_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output etp_pkg::cmd_t      head_cmd
);
  import etp_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/etp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result emitter
// Walks the head command one result per cycle into an output register while the receiver is ready.
// ----------------------------------------------------------------------------
module etp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  etp_pkg::cmd_t      head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output etp_pkg::res_t      out_res
);
  import etp_pkg::*;

  logic [5:0] pos;
  logic [5:0] total, j, j2, j3;
  logic       advance, is_last;
  res_t       cur;

  always_comb begin
    total = head_cmd.rel_n + 6'(head_cmd.a_n) + 6'(head_cmd.mark_a)
          + 6'(head_cmd.b_n) + 6'(head_cmd.mark_b);
    j  = pos - head_cmd.rel_n;
    j2 = j - 6'(head_cmd.a_n);
    j3 = j2 - 6'(head_cmd.mark_a);
    is_last = (pos == total - 6'd1);
    cur = '0;
    cur.run_last = is_last;
    if (pos < head_cmd.rel_n) begin
      cur.out_byte     = head_cmd.rel_mask[pos[4:0]] ? CH_TAB : CH_SP;
      cur.byte_valid   = 1'b1;
      cur.segment_kind = head_cmd.kind_a;
    end else if (j < 6'(head_cmd.a_n)) begin
      cur.out_byte     = head_cmd.a_bytes[j[1:0]];
      cur.byte_valid   = 1'b1;
      cur.segment_kind = head_cmd.kind_a;
    end else if (head_cmd.mark_a && j2 == 6'd0) begin
      cur.segment_end  = 1'b1;
      cur.segment_kind = head_cmd.kind_a;
    end else if (j3 < 6'(head_cmd.b_n)) begin
      cur.out_byte     = head_cmd.b_bytes[j3[1:0]];
      cur.byte_valid   = 1'b1;
      cur.segment_kind = head_cmd.kind_b;
    end else begin
      cur.segment_end  = 1'b1;
      cur.segment_kind = head_cmd.kind_b;
    end
  end

  assign advance = head_valid && (!out_valid || out_ready);
  assign pop     = advance && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        pos       <= is_last ? 6'd0 : pos + 6'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= cur;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/embedded_template_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Embedded template tokenizer
// Splits a template byte stream into text, code, put, comment and
// percent-line segments, tagging each output byte with its segment kind.
// ----------------------------------------------------------------------------
// Template bytes enter on the slave stream, one per transfer, with tlast
// marking the last byte of a template. The scanner takes a byte in every
// cycle while its two-entry command queue has room; the emitter then sends
// the results one per cycle while the receiver is ready. A byte causes from
// zero to about forty results, the most when held indent whitespace is
// released. Each result carries a content byte or a segment close marker,
// and tlast flags the last result of one input byte. Configuration writes
// go through the cfg channel and must only be made while the block is
// idle.
module embedded_template_tokenizer #(
  parameter int WS_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tlast,   // end_of_template
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] segment_end
  output logic [3:0]       m_tuser,   // [0] byte_valid, [3:1] segment_kind
  output logic             m_tlast,   // run_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [1:0]  cfg_data
);
  import etp_pkg::*;

  logic [1:0] trim_select;
  logic       percent_lines;
  logic       dash_trim;
  logic       push, q_full, pop, head_valid;
  cmd_t       push_cmd, head_cmd;
  res_t       out_res;

  // Configuration registers; writes to unlisted indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_select   <= 2'd0;
      percent_lines <= 1'b0;
      dash_trim     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRIM_SELECT:   trim_select   <= cfg_data;
        REG_PERCENT_LINES: percent_lines <= cfg_data[0];
        REG_DASH_TRIM:     dash_trim     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The front end scans one byte per transfer and builds a command.
  etp_front #(.WS_DEPTH(WS_DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .in_last      (s_tlast),
    .trim_select  (trim_select),
    .percent_lines(percent_lines),
    .dash_trim    (dash_trim),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  etp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  // The back end expands each command into results.
  etp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {7'b0000000, out_res.segment_end, out_res.out_byte};
  assign m_tuser = {out_res.segment_kind, out_res.byte_valid};
  assign m_tlast = out_res.run_last;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Embedded template tokenizer testbench
// Drives template bytes with random gaps and output stalls, predicts every
// tagged output byte and segment marker, and compares them in order.
// ----------------------------------------------------------------------------
module testbench;
  import etp_pkg::*;

  // The scan phases of the predictor follow the package enum.
  localparam int HOLD_LIMIT = 32;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [1:0]  cfg_data;

  embedded_template_tokenizer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Expected result transfers, oldest first. Each entry holds byte [7:0],
  // byte_valid [8], segment_kind [11:9], segment_end [12] and run_last [13].
  logic [13:0] pending_results[$];
  int errors = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int sender_idle_pct = 23;
  int receiver_idle_pct = 23;
  int hold_off_cycles = 0;

  // Predictor copy of configuration and scanner state.
  logic [1:0] p_trim;
  logic       p_pct;
  logic       p_dash;
  phase_t     p_phase;
  logic       p_alh, p_tbl, p_has, p_lwo;
  logic [2:0] p_kind;
  int         p_cnt;
  logic       p_held[HOLD_LIMIT];
  logic [13:0] step_out[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout after %0d bytes", bytes_sent);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void put_res(logic [7:0] b, logic v, logic e);
    step_out.push_back({1'b0, e, p_kind, v, b});
  endfunction

  function automatic void emit(logic [7:0] b);
    put_res(b, 1'b1, 1'b0);
    p_has = 1'b1;
  endfunction

  function automatic void close_seg();
    if (p_has) put_res(8'h00, 1'b0, 1'b1);
    p_has = 1'b0;
  endfunction

  function automatic void open_seg(logic [2:0] k);
    p_kind = k;
    p_has = 1'b0;
    p_lwo = 1'b1;
  endfunction

  function automatic void release_indent();
    for (int i = 0; i < p_cnt; i++) emit(p_held[i] ? CH_TAB : CH_SP);
    p_cnt = 0;
  endfunction

  function automatic void restart_scan();
    p_phase = PH_TEXT;
    p_alh = 1'b1;
    p_tbl = 1'b0;
    p_kind = KIND_TEXT;
    p_has = 1'b0;
    p_cnt = 0;
    p_lwo = 1'b1;
  endfunction

  function automatic void scan_text(logic [7:0] b);
    p_phase = PH_TEXT;
    if (b == CH_LT) begin
      p_tbl = p_alh;
      p_alh = 1'b0;
      p_phase = PH_LT;
    end else if (b == CH_PCT && p_alh && p_pct) begin
      p_alh = 1'b0;
      p_phase = PH_PCTHEAD;
    end else if (b == CH_SP || b == CH_TAB) begin
      p_alh = 1'b0;
      if (p_lwo && p_dash && p_cnt < HOLD_LIMIT) begin
        p_held[p_cnt] = (b == CH_TAB);
        p_cnt++;
      end else begin
        release_indent();
        p_lwo = 1'b0;
        emit(b);
      end
    end else begin
      release_indent();
      emit(b);
      p_alh = (b == CH_LF);
      p_lwo = (b == CH_LF);
    end
  endfunction

  function automatic void scan_body(logic [7:0] b);
    p_phase = PH_BODY;
    if (b == CH_PCT) p_phase = PH_BPCT;
    else if (b == CH_DASH && p_dash) p_phase = PH_BDASH;
    else emit(b);
  endfunction

  function automatic void close_tag(logic dash);
    close_seg();
    open_seg(KIND_TEXT);
    if (dash || p_trim == TRIM_ALWAYS || (p_trim == TRIM_LINE_HEAD && p_tbl)) begin
      p_phase = PH_TRIM;
    end else begin
      p_phase = PH_TEXT;
      p_alh = 1'b0;
    end
  endfunction

  function automatic void scan_after_pct(logic [7:0] b);
    if (b == CH_GT) close_tag(1'b0);
    else if (b == CH_PCT) p_phase = PH_BPCTPCT;
    else begin
      emit(CH_PCT);
      scan_body(b);
    end
  endfunction

  function automatic void open_tag(logic [2:0] k);
    release_indent();
    close_seg();
    open_seg(k);
    p_phase = PH_BODY;
  endfunction

  function automatic void pline_byte(logic [7:0] b);
    emit(b);
    if (b == CH_LF) begin
      close_seg();
      open_seg(KIND_TEXT);
      p_alh = 1'b1;
      p_phase = PH_TEXT;
    end
  endfunction

  // Works out every result one template byte causes and queues them.
  task automatic tokenize_byte(input logic [7:0] b, input logic last);
    step_out.delete();
    case (p_phase)
      PH_LT: begin
        if (b == CH_PCT) p_phase = PH_LTPCT;
        else begin
          release_indent();
          emit(CH_LT);
          p_lwo = 1'b0;
          scan_text(b);
        end
      end
      PH_LTPCT: begin
        if (b == CH_PCT) begin
          release_indent();
          emit(CH_LT);
          emit(CH_PCT);
          p_lwo = 1'b0;
          p_phase = PH_TEXT;
        end else if (b == CH_EQ) open_tag(KIND_PUT);
        else if (b == CH_HASH) open_tag(KIND_COMMENT);
        else if (b == CH_DASH && p_dash && !last) begin
          p_cnt = 0;
          open_tag(KIND_CODE);
        end else begin
          open_tag(KIND_CODE);
          scan_body(b);
        end
      end
      PH_PCTHEAD: begin
        release_indent();
        if (b == CH_PCT) begin
          emit(CH_PCT);
          p_lwo = 1'b0;
          p_phase = PH_TEXT;
        end else begin
          close_seg();
          open_seg(KIND_PLINE);
          p_phase = PH_PLINE;
          pline_byte(b);
        end
      end
      PH_PLINE: pline_byte(b);
      PH_BODY: scan_body(b);
      PH_BPCT: scan_after_pct(b);
      PH_BPCTPCT: begin
        if (b == CH_GT) begin
          emit(CH_PCT);
          emit(CH_GT);
          p_phase = PH_BODY;
        end else if (b == CH_PCT) emit(CH_PCT);
        else begin
          emit(CH_PCT);
          emit(CH_PCT);
          scan_body(b);
        end
      end
      PH_BDASH: begin
        if (b == CH_PCT) p_phase = PH_BDASHPCT;
        else begin
          emit(CH_DASH);
          scan_body(b);
        end
      end
      PH_BDASHPCT: begin
        if (b == CH_GT) close_tag(1'b1);
        else begin
          emit(CH_DASH);
          p_phase = PH_BPCT;
          scan_after_pct(b);
        end
      end
      PH_TRIM: begin
        if (b == CH_CR) begin
          p_alh = 1'b1;
          p_phase = PH_TRIMCR;
        end else if (b == CH_LF) begin
          p_alh = 1'b1;
          p_phase = PH_TEXT;
        end else begin
          p_alh = 1'b0;
          scan_text(b);
        end
      end
      PH_TRIMCR: begin
        p_alh = 1'b1;
        if (b == CH_LF) p_phase = PH_TEXT;
        else scan_text(b);
      end
      default: scan_text(b);
    endcase
    if (last) begin
      // End of template: flush what is pending and close the open segment.
      release_indent();
      case (p_phase)
        PH_LT: emit(CH_LT);
        PH_BPCT: emit(CH_PCT);
        PH_BPCTPCT: begin
          emit(CH_PCT);
          emit(CH_PCT);
        end
        PH_BDASH: emit(CH_DASH);
        PH_BDASHPCT: begin
          emit(CH_DASH);
          emit(CH_PCT);
        end
        default: ;
      endcase
      close_seg();
      restart_scan();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1][13] = 1'b1;
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
  endtask

  // Sends one template byte; the expectation is queued as the transfer lands.
  // The valid stays up after the transfer so that the next byte can follow
  // at once; drain() drops it when sending stops.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokenize_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Waits until every expected result is out, then idles for some slack.
  task automatic drain();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    while (pending_results.size() > 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_TRIM_SELECT) p_trim = val;
    else if (idx == REG_PERCENT_LINES) p_pct = val[0];
    else if (idx == REG_DASH_TRIM) p_dash = val[0];
    @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] trim, input logic pct, input logic dash);
    drain();
    write_reg(REG_TRIM_SELECT, trim);
    write_reg(REG_PERCENT_LINES, {1'b0, pct});
    write_reg(REG_DASH_TRIM, {1'b0, dash});
    cfg_valid <= 1'b0;
  endtask

  // Result checker: each transfer on the master side is matched with the
  // oldest expectation.
  always @(posedge clk) begin
    logic [13:0] got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata[8], m_tuser[3:1], m_tuser[0], m_tdata[7:0]};
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_tdata[15:9] !== 7'd0) begin
          $display("%0t: mismatch, expected byte %h valid %b kind %0d end %b last %b,",
                   $time, want[7:0], want[8], want[11:9], want[12], want[13]);
          $display("%0t:   actual byte %h valid %b kind %0d end %b last %b",
                   $time, m_tdata[7:0], m_tuser[0], m_tuser[3:1], m_tdata[8], m_tlast);
          errors++;
        end
      end
    end
  end

  // Receiver readiness: random stalls, or a long hold-off counted here.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      m_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  function automatic logic [7:0] rand_template_byte();
    int r;
    r = $urandom_range(99);
    if (r < 12) return CH_LT;
    if (r < 26) return CH_PCT;
    if (r < 32) return CH_GT;
    if (r < 38) return CH_DASH;
    if (r < 41) return CH_EQ;
    if (r < 44) return CH_HASH;
    if (r < 50) return CH_LF;
    if (r < 53) return CH_CR;
    if (r < 60) return CH_SP;
    if (r < 64) return CH_TAB;
    if (r < 84) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(255));
  endfunction

  // Well-formed pieces with random content, mixed with raw noise.
  task automatic send_random_piece();
    int kind, n;
    kind = $urandom_range(9);
    case (kind)
      0: send_string("<%= x %>", 1'b0);
      1: send_string("<%- y -%>\n", 1'b0);
      2: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte($urandom_range(1) ? CH_SP : CH_TAB, 1'b0);
        send_string("<%- z %>\r\n", 1'b0);
      end
      3: send_string("\n% code\n%%x\n", 1'b0);
      4: send_string("<%# c %%> %>\n", 1'b0);
      5: send_string("a <%% b <%a%>", 1'b0);
      default: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_byte(rand_template_byte(), 1'b0);
      end
    endcase
  endtask

  task automatic test_directed_basics();
    configure(2'd0, 1'b0, 1'b0);
    send_string("ab<%x%>c", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_string("<%=p%><%#q%>x<y<%%z", 1'b1);
    send_string("<%a%%>b", 1'b1);
    send_string("<%-d", 1'b1);
    send_string("<%", 1'b1);
  endtask

  task automatic test_trim_modes();
    configure(2'd1, 1'b0, 1'b0);
    send_string("<%a%>\nx<%b%>\r\ny", 1'b1);
    configure(2'd2, 1'b0, 1'b0);
    send_string("<%a%>\nq <%b%>\nz", 1'b1);
    configure(2'd3, 1'b0, 1'b0);
    send_string("<%a%>\nw", 1'b1);
  endtask

  task automatic test_percent_and_dash();
    configure(2'd0, 1'b1, 1'b1);
    send_string("%x=1\n%%y\n  <%- a -%>\r\nb", 1'b1);
    // More indent than can be held releases it all as text.
    for (int i = 0; i < 34; i++) send_byte(CH_SP, 1'b0);
    send_string("<%-c%>", 1'b1);
    send_string("%", 1'b1);
  endtask

  // Random templates under several settings; one phase holds the receiver
  // off long enough that the block backs up and stalls its input.
  task automatic test_random_templates();
    int phases;
    phases = 6;
    for (int ph = 0; ph < phases; ph++) begin
      configure(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (ph == 2) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end else begin
        sender_idle_pct = 23;
        receiver_idle_pct = 23;
      end
      if (ph == 3) hold_off_cycles = 300;
      for (int k = 0; k < 6; k++) send_random_piece();
      send_byte(rand_template_byte(), 1'b1);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_TRIM_SELECT;
    cfg_data = 2'd0;
    p_trim = 2'd0;
    p_pct = 1'b0;
    p_dash = 1'b0;
    restart_scan();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_basics();
    test_trim_modes();
    test_percent_and_dash();
    test_random_templates();
    drain();

    $display("Sent %0d template bytes and checked %0d results", bytes_sent, results_seen);
    $display("under all trim modes, percent lines and dash trimming; %0d left over.",
             pending_results.size());
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
